// ===== rtl/core/kwlex_pkg.sv =====
// Package for the keyword token lexer: token kind codes, result word layout,
// character classes and the keyword table.
// No dependencies; imported by keyword_token_lexer_unit.
package kwlex_pkg;

   // Default sizes of the internal position counters and the keyword buffer
   localparam int OFFSET_WIDTH_DEF  = 24;
   localparam int LINE_WIDTH_DEF    = 16;
   localparam int KEYWORD_CHARS_DEF = 6;

   // Fixed widths of the result fields
   localparam int KIND_WIDTH   = 5;
   localparam int START_WIDTH  = 24;
   localparam int LENGTH_WIDTH = 24;
   localparam int POS_WIDTH    = 16;
   localparam int BYTE_WIDTH   = 8;

   // Result word: start, length, line, column, zero fill to whole bytes
   localparam int RSP_FIELDS_WIDTH = START_WIDTH + LENGTH_WIDTH + 2 * POS_WIDTH;
   localparam int RSP_DATA_WIDTH   = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;

   // Longest keyword, and its text as one word with the first char on top
   localparam int KW_MAX_CHARS  = 6;
   localparam int KW_TEXT_WIDTH = KW_MAX_CHARS * BYTE_WIDTH;

   // Result queue
   localparam int QUEUE_DEPTH = 3;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_DOT     = ".";
   localparam logic [7:0] CHAR_GT      = ">";
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_EQUALS  = "=";

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_LPAREN   = 5'd0,
      KIND_RPAREN   = 5'd1,
      KIND_LBRACKET = 5'd2,
      KIND_RBRACKET = 5'd3,
      KIND_LET      = 5'd4,
      KIND_LESS     = 5'd5,
      KIND_GREATER  = 5'd6,
      KIND_EXTERN   = 5'd7,
      KIND_FN       = 5'd8,
      KIND_IF       = 5'd9,
      KIND_THEN     = 5'd10,
      KIND_ELSE     = 5'd11,
      KIND_ARROW    = 5'd12,
      KIND_COLON    = 5'd13,
      KIND_SEMI     = 5'd14,
      KIND_PLUS     = 5'd15,
      KIND_NAME     = 5'd16,
      KIND_STRING   = 5'd17,
      KIND_NUMBER   = 5'd18,
      KIND_BOOL     = 5'd19,
      KIND_END      = 5'd20,
      KIND_EQUALS   = 5'd21,
      KIND_BADCHAR  = 5'd22,
      KIND_UNTERM   = 5'd23
   } token_kind_type;

   typedef struct packed {
      token_kind_type               kind;
      logic [START_WIDTH-1:0]       start;
      logic [LENGTH_WIDTH-1:0]      length;
      logic [POS_WIDTH-1:0]         line;
      logic [POS_WIDTH-1:0]         column;
      logic                         last;
   } token_type;

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= "0") && (ch <= "9");
   endfunction

   function automatic logic is_name_char(input logic [7:0] ch);
      return is_digit(ch) || ((ch >= "a") && (ch <= "z")) ||
             ((ch >= "A") && (ch <= "Z")) || (ch == CHAR_DOT);
   endfunction

   function automatic logic is_space(input logic [7:0] ch);
      return (ch == " ") || ((ch >= 8'd9) && (ch <= 8'd13));
   endfunction

   function automatic logic is_punct(input logic [7:0] ch);
      return (ch == "(") || (ch == ")") || (ch == "[") || (ch == "]") ||
             (ch == "<") || (ch == ">") || (ch == ":") || (ch == ";") ||
             (ch == "+");
   endfunction

   function automatic token_kind_type punct_kind(input logic [7:0] ch);
      token_kind_type kind;
      unique case (ch)
         "(":     kind = KIND_LPAREN;
         ")":     kind = KIND_RPAREN;
         "[":     kind = KIND_LBRACKET;
         "]":     kind = KIND_RBRACKET;
         "<":     kind = KIND_LESS;
         ">":     kind = KIND_GREATER;
         ":":     kind = KIND_COLON;
         ";":     kind = KIND_SEMI;
         "+":     kind = KIND_PLUS;
         default: kind = KIND_BADCHAR;
      endcase
      return kind;
   endfunction

   // text holds the first chars of the name, first char in the top byte;
   // len is the name length, capped at 7 (never a keyword)
   function automatic token_kind_type keyword_kind(input logic [KW_TEXT_WIDTH-1:0] text,
                                                   input logic [2:0] len);
      token_kind_type kind;
      kind = KIND_NAME;
      if (len == 3'd2) begin
         if (text[47:32] == "fn") kind = KIND_FN;
         else if (text[47:32] == "if") kind = KIND_IF;
      end else if (len == 3'd3) begin
         if (text[47:24] == "let") kind = KIND_LET;
      end else if (len == 3'd4) begin
         if (text[47:16] == "then") kind = KIND_THEN;
         else if (text[47:16] == "else") kind = KIND_ELSE;
         else if (text[47:16] == "true") kind = KIND_BOOL;
      end else if (len == 3'd5) begin
         if (text[47:8] == "false") kind = KIND_BOOL;
      end else if (len == 3'd6) begin
         if (text == "extern") kind = KIND_EXTERN;
      end
      return kind;
   endfunction

endpackage

// ===== rtl/core/keyword_token_lexer_unit.sv =====
// Keyword token lexer top level: byte scanner, keyword match and result queue.
// Depends on kwlex_pkg.

// Source text enters one byte per word on the req side; req_tuser high marks
// the end of the text (the byte is ignored), which flushes a pending token,
// sends an end token and returns the scanner to its reset state. A byte is
// taken in every cycle while fewer than two tokens wait in the three-entry
// result queue; each byte gives zero, one or two tokens, which are in the queue
// in the cycle after the byte is taken, and the rsp side sends at most one token
// per cycle, so a byte that yields two tokens needs output bandwidth for both.
// Bad characters and unterminated strings come out as error tokens, and
// after a bad character the bytes up to the end of text are counted but
// dropped. Offset, length, line and column saturate.
module keyword_token_lexer_unit
   import kwlex_pkg::*;
#(
   parameter int OFFSET_WIDTH  = OFFSET_WIDTH_DEF,
   parameter int LINE_WIDTH    = LINE_WIDTH_DEF,
   parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [BYTE_WIDTH-1:0]     req_tdata,   // text_byte
   input  logic                      req_tuser,   // end_of_text
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // start_offset[23:0], token_length[47:24], end_line[63:48], end_column[79:64]
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic [KIND_WIDTH-1:0]     rsp_tuser,   // token_kind
   output logic                      rsp_tlast    // last_of_run
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_EQUALS,
      MODE_NUMBER,
      MODE_NAME,
      MODE_STRING,
      MODE_ERROR
   } scan_mode_type;

   scan_mode_type             mode_ff, mode_in;
   logic [OFFSET_WIDTH-1:0]   offset_ff, offset_in;
   logic [LINE_WIDTH-1:0]     line_ff, line_in;
   logic [LINE_WIDTH-1:0]     column_ff, column_in;
   logic [OFFSET_WIDTH-1:0]   tstart_ff, tstart_in;
   logic [OFFSET_WIDTH-1:0]   run_ff, run_in;
   logic [7:0]                prefix_ff [KEYWORD_CHARS];
   logic [7:0]                prefix_in [KEYWORD_CHARS];
   token_type                 queue_ff [QUEUE_DEPTH];
   token_type                 queue_in [QUEUE_DEPTH];
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;

   logic                      accept;
   logic                      pop;
   logic [7:0]                text_byte;
   logic [OFFSET_WIDTH-1:0]   offset_adv;
   logic [LINE_WIDTH-1:0]     line_adv;
   logic [LINE_WIDTH-1:0]     column_adv;
   logic [OFFSET_WIDTH-1:0]   run_adv;
   logic [KW_TEXT_WIDTH-1:0]  kw_text;
   logic [2:0]                kw_len;
   token_kind_type            name_kind;

   // First token (pending one, at the position before this byte) and second
   // token (caused by this byte, or the end token)
   logic                      a_valid, b_valid;
   token_kind_type            a_kind, b_kind;
   logic [OFFSET_WIDTH-1:0]   a_start, b_start;
   logic [OFFSET_WIDTH-1:0]   a_len, b_len;
   logic [LINE_WIDTH-1:0]     b_line, b_column;
   logic                      fresh;
   token_type                 tok_a, tok_b, res0, res1;
   logic [1:0]                res_count;
   token_type                 shifted [QUEUE_DEPTH];
   logic [COUNT_WIDTH-1:0]    base;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (count_ff <= COUNT_WIDTH'(QUEUE_DEPTH - 2));
   assign pop        = (count_ff != '0) && rsp_tready;
   assign text_byte  = req_tdata;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser  = queue_ff[0].kind;
   assign rsp_tlast  = queue_ff[0].last;
   assign rsp_tdata  = RSP_DATA_WIDTH'({queue_ff[0].column, queue_ff[0].line,
                                        queue_ff[0].length, queue_ff[0].start});

   // Saturating position advance for the current byte
   always_comb begin
      offset_adv = (&offset_ff) ? offset_ff : offset_ff + 1'b1;
      run_adv    = (&run_ff) ? run_ff : run_ff + 1'b1;
      if (text_byte == CHAR_NEWLINE) begin
         line_adv   = (&line_ff) ? line_ff : line_ff + 1'b1;
         column_adv = '0;
      end else begin
         line_adv   = line_ff;
         column_adv = (&column_ff) ? column_ff : column_ff + 1'b1;
      end
   end

   // Keyword match on the buffered name head
   always_comb begin
      for (int i = 0; i < KW_MAX_CHARS; i++) begin
         kw_text[KW_TEXT_WIDTH-1-8*i -: 8] = prefix_ff[i];
      end
      kw_len    = (run_ff > OFFSET_WIDTH'(7)) ? 3'd7 : run_ff[2:0];
      name_kind = keyword_kind(kw_text, kw_len);
   end

   // Scanner step for one word
   always_comb begin
      mode_in   = mode_ff;
      offset_in = offset_ff;
      line_in   = line_ff;
      column_in = column_ff;
      tstart_in = tstart_ff;
      run_in    = run_ff;
      prefix_in = prefix_ff;
      a_valid   = 1'b0;
      a_kind    = KIND_NAME;
      a_start   = tstart_ff;
      a_len     = run_ff;
      b_valid   = 1'b0;
      b_kind    = KIND_END;
      b_start   = offset_ff;
      b_len     = '0;
      b_line    = line_adv;
      b_column  = column_adv;
      fresh     = 1'b0;

      if (req_tuser) begin
         // flush, send the end token, back to the reset state
         unique case (mode_ff)
            MODE_EQUALS: begin
               a_valid = 1'b1;
               a_kind  = KIND_EQUALS;
               a_len   = OFFSET_WIDTH'(1);
            end
            MODE_NUMBER: begin
               a_valid = 1'b1;
               a_kind  = KIND_NUMBER;
            end
            MODE_NAME: begin
               a_valid = 1'b1;
               a_kind  = name_kind;
            end
            MODE_STRING: begin
               a_valid = 1'b1;
               a_kind  = KIND_UNTERM;
            end
            default: begin
               a_valid = 1'b0;
            end
         endcase
         b_valid   = 1'b1;
         b_line    = line_ff;
         b_column  = column_ff;
         mode_in   = MODE_IDLE;
         offset_in = '0;
         line_in   = '0;
         column_in = '0;
         tstart_in = '0;
         run_in    = '0;
      end else begin
         // every byte moves the position exactly once
         offset_in = offset_adv;
         line_in   = line_adv;
         column_in = column_adv;
         unique case (mode_ff)
            MODE_EQUALS: begin
               mode_in = MODE_IDLE;
               if (text_byte == CHAR_GT) begin
                  b_valid = 1'b1;
                  b_kind  = KIND_ARROW;
                  b_start = tstart_ff;
                  b_len   = OFFSET_WIDTH'(2);
               end else begin
                  a_valid = 1'b1;
                  a_kind  = KIND_EQUALS;
                  a_len   = OFFSET_WIDTH'(1);
                  fresh   = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit(text_byte)) begin
                  run_in = run_adv;
               end else begin
                  a_valid = 1'b1;
                  a_kind  = KIND_NUMBER;
                  fresh   = 1'b1;
               end
            end
            MODE_NAME: begin
               if (is_name_char(text_byte)) begin
                  for (int i = 0; i < KEYWORD_CHARS; i++) begin
                     if (run_ff == OFFSET_WIDTH'(i)) prefix_in[i] = text_byte;
                  end
                  run_in = run_adv;
               end else begin
                  a_valid = 1'b1;
                  a_kind  = name_kind;
                  fresh   = 1'b1;
               end
            end
            MODE_STRING: begin
               if (text_byte == CHAR_QUOTE) begin
                  b_valid = 1'b1;
                  b_kind  = KIND_STRING;
                  b_start = tstart_ff;
                  b_len   = run_ff;
                  mode_in = MODE_IDLE;
               end else begin
                  run_in = run_adv;
               end
            end
            MODE_ERROR: begin
               mode_in = MODE_ERROR;
            end
            default: begin
               fresh = 1'b1;
            end
         endcase

         // start a new token with this byte
         if (fresh) begin
            mode_in = MODE_IDLE;
            if (is_space(text_byte)) begin
               mode_in = MODE_IDLE;
            end else if (is_punct(text_byte)) begin
               b_valid = 1'b1;
               b_kind  = punct_kind(text_byte);
               b_start = offset_ff;
               b_len   = OFFSET_WIDTH'(1);
            end else if (text_byte == CHAR_EQUALS) begin
               tstart_in = offset_ff;
               mode_in   = MODE_EQUALS;
            end else if (text_byte == CHAR_QUOTE) begin
               tstart_in = offset_adv;
               run_in    = '0;
               mode_in   = MODE_STRING;
            end else if (is_digit(text_byte)) begin
               tstart_in = offset_ff;
               run_in    = OFFSET_WIDTH'(1);
               mode_in   = MODE_NUMBER;
            end else if (is_name_char(text_byte)) begin
               tstart_in    = offset_ff;
               prefix_in[0] = text_byte;
               run_in       = OFFSET_WIDTH'(1);
               mode_in      = MODE_NAME;
            end else begin
               b_valid = 1'b1;
               b_kind  = KIND_BADCHAR;
               b_start = offset_ff;
               b_len   = OFFSET_WIDTH'(1);
               mode_in = MODE_ERROR;
            end
         end
      end

      tok_a.kind   = a_kind;
      tok_a.start  = START_WIDTH'(a_start);
      tok_a.length = LENGTH_WIDTH'(a_len);
      tok_a.line   = POS_WIDTH'(line_ff);
      tok_a.column = POS_WIDTH'(column_ff);
      tok_a.last   = !b_valid;

      tok_b.kind   = b_kind;
      tok_b.start  = START_WIDTH'(b_start);
      tok_b.length = LENGTH_WIDTH'(b_len);
      tok_b.line   = POS_WIDTH'(b_line);
      tok_b.column = POS_WIDTH'(b_column);
      tok_b.last   = 1'b1;

      // compact the two candidates into result order
      res0      = a_valid ? tok_a : tok_b;
      res1      = tok_b;
      res_count = {1'b0, a_valid} + {1'b0, b_valid};
   end

   // Result queue: slot 0 is the head; pop shifts down, new tokens append
   always_comb begin
      shifted[0] = queue_ff[1];
      shifted[1] = queue_ff[2];
      shifted[2] = queue_ff[2];
      base       = count_ff - COUNT_WIDTH'(pop);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (COUNT_WIDTH'(i) < base) begin
            queue_in[i] = pop ? shifted[i] : queue_ff[i];
         end else if (COUNT_WIDTH'(i) == base) begin
            queue_in[i] = res0;
         end else begin
            queue_in[i] = res1;
         end
      end
      count_in = base + (accept ? COUNT_WIDTH'(res_count) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         offset_ff <= '0;
         line_ff   <= '0;
         column_ff <= '0;
         tstart_ff <= '0;
         run_ff    <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            mode_ff   <= mode_in;
            offset_ff <= offset_in;
            line_ff   <= line_in;
            column_ff <= column_in;
            tstart_ff <= tstart_in;
            run_ff    <= run_in;
         end
      end
      if (accept) begin
         prefix_ff <= prefix_in;
      end
      queue_ff <= queue_in;
   end

endmodule
